// ===== rtl/core/ull_pkg.sv =====
package ull_pkg;

	localparam int unsigned SEQ_MAX     = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] FOLD_RESET  = 8'd69;
	localparam logic [7:0] CH_BSLASH   = 8'h5c;
	localparam logic [7:0] CH_NEWLINE  = 8'h0a;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DEL      = 8'h7f;

	// One expanded command: the bytes an item produces and the index of the final one.
	typedef struct packed {
		logic [SEQ_MAX-1:0][7:0] seq;
		logic [2:0]              last_idx;
	} ull_cmd_t;

	// Letter of a backslash-letter escape, or zero where the byte has none.
	function automatic logic [7:0] esc_letter(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h5c:   r = 8'h5c;
			8'h07:   r = 8'h61;
			8'h08:   r = 8'h62;
			8'h0c:   r = 8'h66;
			8'h0a:   r = 8'h6e;
			8'h0d:   r = 8'h72;
			8'h09:   r = 8'h74;
			8'h0b:   r = 8'h76;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/unambiguous_line_lister.sv =====
// Channel   Direction  tdata              tlast         tuser
// s_        in         in_byte[7:0]       end_of_line   empty_line
// m_        out        out_byte[7:0]      last_of_run   -
// cfg_      in         fold_width[7:0]    -             -
//
// The output gives one byte per cycle while m_tready does not stall it. An item produces
// 1 to 8 bytes: mostly 1, 2 for a letter escape, 4 for an octal escape, plus 2 for a
// fold and 2 for the end of a line. An item is taken whenever the command queue has room.
// After reset the column is 0, fold_width is 69 and the queue is empty.
// A stalled output fills the queue; the input then stalls while the column stays put.
module unambiguous_line_lister #(
	parameter int unsigned QUEUE_DEPTH = ull_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,   // fold_width
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // in_byte
	input  logic       s_tlast,
	input  logic       s_tuser,     // empty_line
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // out_byte
	output logic       m_tlast
);
	import ull_pkg::*;

	ull_cmd_t front_cmd;
	ull_cmd_t back_cmd;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;
	logic     acc;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && !q_full;

	ull_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.acc         (acc),
		.in_byte     (s_tdata),
		.end_of_line (s_tlast),
		.empty_line  (s_tuser),
		.cmd         (front_cmd)
	);

	ull_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.wr_data  (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (back_cmd)
	);

	ull_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== rtl/core/ull_front.sv =====
module ull_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             acc,
	input  logic [7:0]       in_byte,
	input  logic             end_of_line,
	input  logic             empty_line,
	output ull_pkg::ull_cmd_t cmd
);
	import ull_pkg::*;

	logic [7:0] fold_width_q;
	logic [7:0] column_q;
	logic [7:0] letter;
	logic [2:0] len;
	logic [7:0] piece [4];
	logic [8:0] sum;
	logic       fold;
	logic       line_end;
	logic [1:0] off;
	logic [3:0] count;
	logic [7:0] base;
	logic [3:0] p;

	always_comb begin
		letter = esc_letter(in_byte);
		if (empty_line) begin
			len = 3'd0;
		end else if (letter != 8'h00) begin
			len = 3'd2;
		end else if (in_byte < CH_SPACE || in_byte >= CH_DEL) begin
			len = 3'd4;
		end else begin
			len = 3'd1;
		end
		piece[0] = (len == 3'd1) ? in_byte : CH_BSLASH;
		piece[1] = (len == 3'd2) ? letter : CH_ZERO + {6'd0, in_byte[7:6]};
		piece[2] = CH_ZERO + {5'd0, in_byte[5:3]};
		piece[3] = CH_ZERO + {5'd0, in_byte[2:0]};
		sum      = {1'b0, column_q} + {6'd0, len};
		fold     = !empty_line && (sum > {1'b0, fold_width_q});
		line_end = empty_line || end_of_line;
		off      = fold ? 2'd2 : 2'd0;
		count    = {2'd0, off} + {1'b0, len} + (line_end ? 4'd2 : 4'd0);
		base     = fold ? 8'd0 : column_q;
	end

	// Position j of the sequence: fold pair, then the piece, then the end marker.
	always_comb begin
		cmd.last_idx = 3'(count - 4'd1);
		p = 4'd0;
		for (int j = 0; j < SEQ_MAX; j++) begin
			p = 4'(j) - {2'd0, off};
			if (fold && j < 2) begin
				cmd.seq[j] = (j == 0) ? CH_BSLASH : CH_NEWLINE;
			end else if (p < {1'b0, len}) begin
				cmd.seq[j] = piece[p[1:0]];
			end else if (p == {1'b0, len}) begin
				cmd.seq[j] = CH_DOLLAR;
			end else begin
				cmd.seq[j] = CH_NEWLINE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_width_q <= FOLD_RESET;
			column_q     <= 8'd0;
		end else begin
			if (cfg_we) begin
				fold_width_q <= cfg_wdata;
			end
			if (acc) begin
				column_q <= line_end ? 8'd0 : base + {5'd0, len};
			end
		end
	end

endmodule

// ===== rtl/core/ull_queue.sv =====
module ull_queue #(
	parameter int unsigned DEPTH = ull_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ull_pkg::ull_cmd_t wr_data,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output ull_pkg::ull_cmd_t rd_data
);
	import ull_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ull_cmd_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ull_back.sv =====
module ull_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  ull_pkg::ull_cmd_t cmd,
	output logic              cmd_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);
	import ull_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       advance;
	logic       at_last;

	assign advance  = !out_valid_q || m_tready;
	assign at_last  = (idx_q == cmd.last_idx);
	assign cmd_pop  = advance && cmd_valid && at_last;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (advance && cmd_valid) begin
			out_byte_q <= cmd.seq[idx_q];
			out_last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cmd_valid;
			if (cmd_valid) begin
				idx_q <= at_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

endmodule

// ===== rtl/core/ull_checker.sv =====
module ull_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// Every listed byte is printable or a newline.
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == 8'h0a || (m_tdata >= 8'h20 && m_tdata < 8'h7f)))
		else $error("unprintable byte in listing");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	// The bytes of one item leave without gaps.
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside the bytes of one item");

	// The input is only held off while the output has an item waiting.
	a_stall_backed: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |-> m_tvalid)
		else $error("input stalled with nothing on the output");

endmodule

bind unambiguous_line_lister ull_checker u_ull_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
